### src/nfcuid_pkg.sv
package nfcuid_pkg;

   localparam int NUM_WORDS = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int WORD_W = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] HEADER_LEN = 8'd9;
   localparam logic [7:0] LEN_POS = 8'd9;
   localparam logic [7:0] LEN_CHECK_POS = 8'd10;
   localparam logic [7:0] PAYLOAD_START = 8'd11;
   localparam logic [7:0] UID_START = 8'd19;
   localparam logic [7:0] UID_END = 8'd22;
   localparam logic [7:0] POS_MAX = 8'hFF;
   localparam logic [8:0] LEN_OVERHEAD = 9'd13;
   localparam logic [8:0] MIN_TOTAL = 9'd23;

   localparam logic [WORD_W-1:0] CARD_RESET [NUM_WORDS] = '{
      32'hD2343F96, 32'hAF592904, 32'h3C4F5104, 32'h22E1721B,
      32'h529D1C47, 32'hA0FE9BA5, 32'hB05535BA
   };

   typedef enum logic [1:0] {
      ST_MATCH     = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_SUM_BAD   = 2'd2,
      ST_FRAME_BAD = 2'd3
   } status_type;

   typedef struct packed {
      logic              frame_bad;
      logic              sum_bad;
      logic [WORD_W-1:0] uid;
   } frame_rec_type;

   // acknowledge frame and preamble: 00 00 FF 00 FF 00 00 00 FF
   function automatic logic [7:0] header_byte(input logic [3:0] pos);
      logic [7:0] value;
      case (pos)
         4'd2, 4'd4, 4'd8: value = 8'hFF;
         default:          value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

### src/nfcuid_parser.sv
module nfcuid_parser
   import nfcuid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [7:0]    rx_byte,
   input  logic          last_byte,
   output logic          rec_push,
   output frame_rec_type rec
);

   logic [7:0]        pos_ff, pos_in;
   logic              hdr_good_ff, hdr_good_in;
   logic [7:0]        len_val_ff, len_val_in;
   logic [7:0]        len_sum_ff, len_sum_in;
   logic [7:0]        pay_sum_ff, pay_sum_in;
   logic [WORD_W-1:0] uid_ff, uid_in;
   logic              too_long_ff, too_long_in;
   logic [8:0]        total;

   assign total = {1'b0, pos_ff} + 9'd1;

   always_comb begin
      pos_in      = pos_ff;
      hdr_good_in = hdr_good_ff;
      len_val_in  = len_val_ff;
      len_sum_in  = len_sum_ff;
      pay_sum_in  = pay_sum_ff;
      uid_in      = uid_ff;
      too_long_in = too_long_ff;
      rec_push    = 1'b0;
      rec         = '0;
      if (take) begin
         if (!too_long_ff) begin
            if (pos_ff < HEADER_LEN && rx_byte != header_byte(pos_ff[3:0])) begin
               hdr_good_in = 1'b0;
            end
            if (pos_ff == LEN_POS) begin
               len_val_in = rx_byte;
            end
            if (pos_ff == LEN_POS || pos_ff == LEN_CHECK_POS) begin
               len_sum_in = len_sum_ff + rx_byte;
            end
            if (pos_ff >= PAYLOAD_START && !last_byte) begin
               pay_sum_in = pay_sum_ff + rx_byte;
            end
            if (pos_ff >= UID_START && pos_ff <= UID_END) begin
               uid_in = {uid_ff[WORD_W-9:0], rx_byte};
            end
            if (pos_ff == POS_MAX) begin
               too_long_in = 1'b1;
            end else begin
               pos_in = pos_ff + 8'd1;
            end
         end
         if (last_byte) begin
            rec_push      = 1'b1;
            rec.frame_bad = too_long_in || !hdr_good_in || (len_sum_in != 8'd0) ||
                            ({1'b0, len_val_in} + LEN_OVERHEAD != total) ||
                            (total < MIN_TOTAL);
            rec.sum_bad   = (pay_sum_in != 8'd0);
            rec.uid       = uid_in;
            // drop per-response state
            pos_in      = 8'd0;
            hdr_good_in = 1'b1;
            len_val_in  = 8'd0;
            len_sum_in  = 8'd0;
            pay_sum_in  = 8'd0;
            uid_in      = '0;
            too_long_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 8'd0;
         hdr_good_ff <= 1'b1;
         len_val_ff  <= 8'd0;
         len_sum_ff  <= 8'd0;
         pay_sum_ff  <= 8'd0;
         uid_ff      <= '0;
         too_long_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         hdr_good_ff <= hdr_good_in;
         len_val_ff  <= len_val_in;
         len_sum_ff  <= len_sum_in;
         pay_sum_ff  <= pay_sum_in;
         uid_ff      <= uid_in;
         too_long_ff <= too_long_in;
      end
   end

endmodule

### src/nfcuid_queue.sv
module nfcuid_queue
   import nfcuid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  frame_rec_type wr_data,
   input  logic          rd_en,
   output frame_rec_type rd_data,
   output logic          q_full,
   output logic          q_valid
);

   frame_rec_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_wr, do_rd;

   assign q_full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/nfcuid_matcher.sv
module nfcuid_matcher
   import nfcuid_pkg::*;
#(
   parameter int NUM_CARDS = NUM_WORDS
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata,
   input  logic                   rec_valid,
   input  frame_rec_type          rec,
   output logic                   rec_pop,
   input  logic                   out_pop,
   output logic                   out_valid,
   output logic [1:0]             out_status,
   output logic [2:0]             out_index,
   output logic [WORD_W-1:0]      out_uid
);

   logic [WORD_W-1:0] card_word_ff [NUM_WORDS];
   logic              valid_ff, valid_in;
   status_type        status_ff, status_in;
   logic [2:0]        index_ff, index_in;
   logic [WORD_W-1:0] uid_ff;
   logic              hit;
   logic [2:0]        hit_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         card_word_ff <= CARD_RESET;
      end else if (csr_wr_en && csr_index < CSR_INDEX_W'(NUM_WORDS)) begin
         card_word_ff[csr_index] <= csr_wdata;
      end
   end

   // lowest matching index wins
   always_comb begin
      hit       = 1'b0;
      hit_index = 3'd0;
      for (int k = NUM_CARDS - 1; k >= 0; k--) begin
         if (card_word_ff[k] == rec.uid) begin
            hit       = 1'b1;
            hit_index = 3'(k);
         end
      end
   end

   assign rec_pop = rec_valid && (!valid_ff || out_pop);

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      index_in  = index_ff;
      if (valid_ff && out_pop) begin
         valid_in = 1'b0;
      end
      if (rec_pop) begin
         valid_in = 1'b1;
         index_in = 3'd0;
         if (rec.frame_bad) begin
            status_in = ST_FRAME_BAD;
         end else if (rec.sum_bad) begin
            status_in = ST_SUM_BAD;
         end else if (hit) begin
            status_in = ST_MATCH;
            index_in  = hit_index;
         end else begin
            status_in = ST_UNKNOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
      if (rec_pop) begin
         uid_ff <= rec.uid;
      end
   end

   assign out_valid  = valid_ff;
   assign out_status = status_ff;
   assign out_index  = index_ff;
   assign out_uid    = uid_ff;

endmodule

### src/nfc_frame_uid_matcher.sv
// Response frame checker and card identifier matcher.
// Request side is a queue write port: a response byte (req_rx_byte, with
// req_last_byte on the final byte) is taken at a clock edge with push high
// and full low. One byte per cycle is accepted back to back while full is low.
// Response side is a queue read port: while empty is low, rsp_status,
// rsp_card_index and rsp_card_uid hold the oldest result; pop takes it.
// One result is produced per response, on its last byte; other bytes
// produce none.
// A result passes the record queue and then the output register: the taking
// edge writes the record queue, and the output register loads it once free.
// The matcher compares the identifier against the first NUM_CARDS card words
// combinationally, so results drain one per cycle while pop is held high.
// When pop stays low the output register and the two-entry record queue
// fill, then full rises and bytes are held off until space frees.
// Card words are written through csr_wr_en/csr_index/csr_wdata, by the user
// only while idle (unenforced); indexes beyond the last word are ignored.
// Reset (synchronous) restores the card words to their defaults and clears
// the parser state, the record queue and the output valid flag.
module nfc_frame_uid_matcher
   import nfcuid_pkg::*;
#(
   parameter int NUM_CARDS = NUM_WORDS
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_last_byte,
   output logic                   empty,
   input  logic                   pop,
   output logic [1:0]             rsp_status,
   output logic [2:0]             rsp_card_index,
   output logic [WORD_W-1:0]      rsp_card_uid,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   logic          take;
   logic          rec_push;
   frame_rec_type rec_in;
   frame_rec_type rec_out;
   logic          rec_valid;
   logic          rec_pop;
   logic          q_full;
   logic          out_valid;

   assign take  = push && !q_full;
   assign full  = q_full;
   assign empty = !out_valid;

   nfcuid_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .last_byte (req_last_byte),
      .rec_push  (rec_push),
      .rec       (rec_in)
   );

   nfcuid_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_push),
      .wr_data (rec_in),
      .rd_en   (rec_pop),
      .rd_data (rec_out),
      .q_full  (q_full),
      .q_valid (rec_valid)
   );

   nfcuid_matcher #(
      .NUM_CARDS (NUM_CARDS)
   ) u_matcher (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rec_valid  (rec_valid),
      .rec        (rec_out),
      .rec_pop    (rec_pop),
      .out_pop    (pop),
      .out_valid  (out_valid),
      .out_status (rsp_status),
      .out_index  (rsp_card_index),
      .out_uid    (rsp_card_uid)
   );

endmodule
